// File: design/dbps_pkg.sv
// Shared types and constants for the packed-stamp day counter.
// Used by dbps_day_step, days_between_packed_stamps_core, dbps_checker and tb; no dependencies.
package dbps_pkg;

  localparam int STAMP_W     = 32;
  localparam int COUNT_W     = 15;
  localparam int TIME_W      = 16;
  localparam int YEAR_W      = 8;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;

  localparam int MAX_DAY_STEPS_DEF = 32767;

  // Month codes for the short months and for the December-to-January wrap
  localparam logic [MONTH_W-1:0] MON_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR  = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN  = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP  = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV  = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC  = 4'd12;
  localparam logic [MONTH_W-1:0] MON_JAN  = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t next_date;
    logic  reached;
  } step_res_t;

endpackage

// File: design/dbps_day_step.sv
// Shared date unit: advances a date by one calendar day and compares it
// against the target date. Depends on dbps_pkg.
module dbps_day_step (
  input  dbps_pkg::date_t     cur_date,
  input  dbps_pkg::date_t     tgt_date,
  output dbps_pkg::step_res_t res
);
  import dbps_pkg::*;

  logic [DAY_W:0]   day_inc;
  logic [MONTH_W:0] mon_inc;
  logic             wrap;
  logic [MONTH_W:0] mon_sel;
  logic [DAY_W-1:0] day_sel;
  date_t            nxt;

  always_comb begin
    day_inc = {1'b0, cur_date.day} + 1'b1;
    wrap    = 1'b0;
    case (day_inc)
      6'd32: wrap = 1'b1;
      6'd31: wrap = (cur_date.month == MON_FEB) || (cur_date.month == MON_APR) ||
                    (cur_date.month == MON_JUN) || (cur_date.month == MON_SEP) ||
                    (cur_date.month == MON_NOV);
      6'd30: wrap = (cur_date.month == MON_FEB);
      6'd29: wrap = (cur_date.month == MON_FEB) && (cur_date.year[1:0] != 2'd0);
      default: wrap = 1'b0;
    endcase

    mon_inc = {1'b0, cur_date.month} + 1'b1;
    mon_sel = wrap ? mon_inc : {1'b0, cur_date.month};
    day_sel = wrap ? DAY_FIRST : day_inc[DAY_W-1:0];

    nxt.day = day_sel;
    if (mon_sel > {1'b0, MON_DEC}) begin
      nxt.month = MON_JAN;
      nxt.year  = cur_date.year + 1'b1;
    end else begin
      nxt.month = mon_sel[MONTH_W-1:0];
      nxt.year  = cur_date.year;
    end

    res.next_date = nxt;
    if (cur_date.year != tgt_date.year) begin
      res.reached = cur_date.year > tgt_date.year;
    end else if (cur_date.month != tgt_date.month) begin
      res.reached = cur_date.month > tgt_date.month;
    end else begin
      res.reached = cur_date.day >= tgt_date.day;
    end
  end

endmodule

// File: design/days_between_packed_stamps_core.sv
// Top level of the packed-stamp day counter: sequencer, count and result.
// Depends on dbps_pkg and dbps_day_step.
//
// Pulse start with both stamps while busy is low; the block then walks
// stamp A's date forward one day per clock through a single shared date
// unit until it reaches stamp B's date or MAX_DAY_STEPS steps are taken.
// The walk takes from 0 to MAX_DAY_STEPS day steps, and busy stays high
// throughout it. out_day_count is valid for exactly the one cycle that
// out_valid is high; the receiver cannot stall it and must take it then.
module days_between_packed_stamps_core #(
  parameter int MAX_DAY_STEPS = dbps_pkg::MAX_DAY_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [dbps_pkg::STAMP_W-1:0]    in_stamp_a,
  input  logic [dbps_pkg::STAMP_W-1:0]    in_stamp_b,
  output logic                            out_valid,
  output logic [dbps_pkg::COUNT_W-1:0]    out_day_count
);
  import dbps_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic [COUNT_W-1:0] STEP_LIMIT = COUNT_W'(MAX_DAY_STEPS);

  state_t             state_r;
  date_t              cur_r;
  date_t              tgt_r;
  logic [TIME_W-1:0]  time_a_r;
  logic [TIME_W-1:0]  time_b_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_cnt_r;
  step_res_t          step_res;
  logic               done;
  logic [COUNT_W-1:0] final_cnt;

  dbps_day_step u_step (
    .cur_date (cur_r),
    .tgt_date (tgt_r),
    .res      (step_res)
  );

  always_comb begin
    done = step_res.reached || (cnt_r >= STEP_LIMIT);
    // drop one day when the count is nonzero and A's time of day is later than B's
    if ((cnt_r != '0) && (time_a_r > time_b_r)) begin
      final_cnt = cnt_r - 1'b1;
    end else begin
      final_cnt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (done) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cur_r.year  <= {1'b0, in_stamp_a[15:9]};
          cur_r.month <= in_stamp_a[8:5];
          cur_r.day   <= in_stamp_a[4:0];
          tgt_r.year  <= {1'b0, in_stamp_b[15:9]};
          tgt_r.month <= in_stamp_b[8:5];
          tgt_r.day   <= in_stamp_b[4:0];
          time_a_r    <= in_stamp_a[31:16];
          time_b_r    <= in_stamp_b[31:16];
          cnt_r       <= '0;
        end
      end
      ST_RUN: begin
        if (done) begin
          out_cnt_r <= final_cnt;
        end else begin
          cur_r <= step_res.next_date;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_day_count = out_cnt_r;

endmodule

// File: test/dbps_checker.sv
// Checker for days_between_packed_stamps_core: watches the command and result ports,
// predicts the day count of every accepted transaction and compares it in order.
// Depends on dbps_pkg.
module dbps_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [dbps_pkg::STAMP_W-1:0] in_stamp_a,
  input  logic [dbps_pkg::STAMP_W-1:0] in_stamp_b,
  input  logic                         out_valid,
  input  logic [dbps_pkg::COUNT_W-1:0] out_day_count,
  output int                           pending,
  output int                           errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbps_pkg::*;

  localparam int unsigned STEP_LIMIT = MAX_DAY_STEPS_DEF;

  typedef struct {
    logic [STAMP_W-1:0] stamp_a;
    logic [STAMP_W-1:0] stamp_b;
    logic [COUNT_W-1:0] day_count;
  } day_count_exp_t;

  day_count_exp_t awaited_counts[$];

  function automatic logic [COUNT_W-1:0] predict_day_count(
    input logic [STAMP_W-1:0] a,
    input logic [STAMP_W-1:0] b
  );
    int unsigned y, m, d, by, bm, bd, steps;
    logic [TIME_W-1:0] tod_a, tod_b;
    logic wrap;
    y = a[15:9];
    m = a[8:5];
    d = a[4:0];
    by = b[15:9];
    bm = b[8:5];
    bd = b[4:0];
    tod_a = a[31:16];
    tod_b = b[31:16];
    steps = 0;
    while (steps < STEP_LIMIT) begin
      if (y != by ? y > by : (m != bm ? m > bm : d >= bd)) break;
      d++;
      // a day only rolls over at 32, or exactly at the end of a short month
      if (d == 32)
        wrap = 1'b1;
      else if (d == 31)
        wrap = (m == MON_FEB || m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV);
      else if (d == 30)
        wrap = (m == MON_FEB);
      else if (d == 29)
        wrap = (m == MON_FEB && (y & 3) != 0);
      else
        wrap = 1'b0;
      if (wrap) begin
        d = DAY_FIRST;
        m++;
      end
      if (m > MON_DEC) begin
        m = MON_JAN;
        y = (y + 1) & 8'hFF;
      end
      steps++;
    end
    // drop the partial day when A's time of day is later than B's
    if (steps != 0 && tod_a > tod_b)
      steps--;
    return steps[COUNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    day_count_exp_t head;
    if (!rst_n) begin
      pending = 0;
      errors = 0;
    end else begin
      if (out_valid) begin
        if (awaited_counts.size() == 0) begin
          $display("%0t: unexpected day_count result: expected none, got %0d",
                   $time, out_day_count);
          errors++;
        end else begin
          head = awaited_counts.pop_front();
          if (out_day_count !== head.day_count) begin
            $display("%0t: day_count mismatch for A=%h B=%h: expected %0d, got %0d",
                     $time, head.stamp_a, head.stamp_b, head.day_count, out_day_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        head.stamp_a = in_stamp_a;
        head.stamp_b = in_stamp_b;
        head.day_count = predict_day_count(in_stamp_a, in_stamp_b);
        awaited_counts.push_back(head);
      end
      pending = awaited_counts.size();
    end
  end

endmodule

// File: test/tb.sv
// Testbench top for days_between_packed_stamps_core: clock, reset, directed and
// random stamp pairs with sender gaps, and the final verdict.
// Depends on dbps_pkg, days_between_packed_stamps_core and dbps_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbps_pkg::*;

  // every transaction at its longest, plus the longest sender gap, three times over
  localparam int unsigned LIMIT_CYCLES = 130 * (MAX_DAY_STEPS_DEF + 2 + 12) * 3;
  localparam int RANDOM_PER_PHASE = 27;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [STAMP_W-1:0] in_stamp_a = '0;
  logic [STAMP_W-1:0] in_stamp_b = '0;
  logic               busy;
  logic               out_valid;
  logic [COUNT_W-1:0] out_day_count;
  int                 pending;
  int                 errors;
  int                 sender_idle_pct = 0;
  int unsigned        cycle_count = 0;
  int                 idle_pcts[3] = '{36, 67, 0};

  always #10 clk = ~clk;

  days_between_packed_stamps_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_stamp_a   (in_stamp_a),
    .in_stamp_b   (in_stamp_b),
    .out_valid    (out_valid),
    .out_day_count(out_day_count)
  );

  dbps_checker day_count_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_stamp_a   (in_stamp_a),
    .in_stamp_b   (in_stamp_b),
    .out_valid    (out_valid),
    .out_day_count(out_day_count),
    .pending      (pending),
    .errors       (errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [STAMP_W-1:0] pack_stamp(
    input int y,
    input int m,
    input int d,
    input logic [TIME_W-1:0] tod
  );
    return {tod, 7'(y), 4'(m), 5'(d)};
  endfunction

  // Hold start until the transaction is taken; start stays high afterwards.
  task automatic send_stamps(input logic [STAMP_W-1:0] a, input logic [STAMP_W-1:0] b);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    in_stamp_a <= a;
    in_stamp_b <= b;
    do @(posedge clk); while (busy);
  endtask

  // Let the checker see the last accepted transaction before waiting on it.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Mostly nearby dates so the walk stays short; some out-of-range fields,
  // some reversed pairs and a few fully random stamps.
  task automatic random_pair(output logic [STAMP_W-1:0] a, output logic [STAMP_W-1:0] b);
    int y, m, d, by, bm, bd, kind;
    logic [STAMP_W-1:0] tmp;
    kind = $urandom_range(99);
    y = $urandom_range(127);
    by = y + $urandom_range(1);
    if (by > 127)
      by = 127;
    if (kind < 70) begin
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 28);
      bm = $urandom_range(1, 12);
      bd = $urandom_range(1, 28);
    end else begin
      m = $urandom_range(15);
      d = $urandom_range(31);
      bm = $urandom_range(15);
      bd = $urandom_range(31);
    end
    a = pack_stamp(y, m, d, TIME_W'($urandom));
    b = pack_stamp(by, bm, bd, TIME_W'($urandom));
    if (kind >= 85 && kind < 95) begin
      tmp = a;
      a = b;
      b = tmp;
    end else if (kind >= 95) begin
      a = $urandom;
      b = $urandom;
    end
  endtask

  initial begin
    logic [STAMP_W-1:0] a, b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ordering, time correction and odd calendar fields
    send_stamps('0, '0);
    send_stamps('1, '1);
    send_stamps('1, '0);
    send_stamps(pack_stamp(50, 6, 1, 0), pack_stamp(49, 6, 1, 0));
    send_stamps(pack_stamp(10, 3, 5, 0), pack_stamp(10, 3, 6, 0));
    send_stamps(pack_stamp(10, 3, 5, 16'hFFFF), pack_stamp(10, 3, 7, 16'h0000));
    send_stamps(pack_stamp(10, 3, 5, 16'hFFFF), pack_stamp(10, 3, 5, 16'h0000));
    send_stamps(pack_stamp(20, 5, 0, 0), pack_stamp(20, 5, 3, 0));
    send_stamps(pack_stamp(1, 2, 27, 0), pack_stamp(1, 3, 2, 0));
    send_stamps(pack_stamp(0, 2, 27, 0), pack_stamp(0, 3, 2, 0));
    send_stamps(pack_stamp(1, 2, 29, 0), pack_stamp(1, 3, 2, 0));
    send_stamps(pack_stamp(5, 4, 31, 0), pack_stamp(5, 5, 3, 0));
    send_stamps(pack_stamp(7, 0, 30, 0), pack_stamp(7, 1, 5, 0));
    send_stamps(pack_stamp(7, 13, 10, 0), pack_stamp(8, 1, 12, 0));
    send_stamps(pack_stamp(7, 15, 31, 0), pack_stamp(8, 2, 2, 0));
    send_stamps(pack_stamp(3, 12, 30, 0), pack_stamp(4, 1, 2, 0));
    send_stamps(pack_stamp(127, 13, 5, 0), pack_stamp(127, 14, 1, 0));
    send_stamps(pack_stamp(127, 12, 31, 0), pack_stamp(127, 15, 31, 0));
    send_stamps(pack_stamp(9, 1, 1, 0), pack_stamp(9, 0, 0, 0));
    send_stamps(pack_stamp(0, 1, 1, 0), pack_stamp(127, 12, 31, 0));
    send_stamps(pack_stamp(0, 1, 1, 16'h8000), pack_stamp(127, 12, 31, 16'h7FFF));
    drain_results();

    foreach (idle_pcts[p]) begin
      sender_idle_pct = idle_pcts[p];
      repeat (RANDOM_PER_PHASE) begin
        random_pair(a, b);
        send_stamps(a, b);
      end
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/dbps_pkg.sv
design/dbps_day_step.sv
design/days_between_packed_stamps_core.sv
test/dbps_checker.sv
test/tb.sv
